### rtl/core/brc_pkg.sv
// Package for the bond relation closure: beat types, register map, defaults.
`default_nettype none
package brc_pkg;

  // Default array sizes
  localparam int DefMaxObjects    = 32;
  localparam int DefMaxAttributes = 32;

  // Fixed field widths
  localparam int RowW     = 32;
  localparam int RowIdxW  = 5;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 14;
  localparam int CountW   = 6;
  localparam int PassW    = 14;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgNumObjects    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNumAttributes = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxPasses     = 2'd2;

  // Register reset values
  localparam logic [CountW-1:0] RstNumObjects    = 6'd32;
  localparam logic [CountW-1:0] RstNumAttributes = 6'd32;
  localparam logic [PassW-1:0]  RstMaxPasses     = 14'd10000;

  typedef struct packed {
    logic [RowW-1:0] context_row;
    logic [RowW-1:0] relation_row;
    logic            last_row;
  } in_beat_t;

  typedef struct packed {
    logic [RowW-1:0]    result_row;
    logic [RowIdxW-1:0] row_index;
    logic               last_result;
    logic               limit_reached;
  } out_beat_t;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic load;
    logic mask;
    logic col_we;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/core/brc_cell.sv
// One object cell: holds a context row and a relation row, passes a closure token on.
`default_nettype none
module brc_cell #(
  parameter int MaxObj  = 32,
  parameter int MaxAttr = 32,
  parameter int CellIdx = 0,
  parameter int KeyW    = (MaxObj > MaxAttr) ? MaxObj : MaxAttr,
  parameter int IdxW    = $clog2(KeyW)
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire brc_pkg::cell_ctrl_t ctrl_i,
  input  wire                    in_use_i,
  input  wire                    load_sel_i,
  input  wire  [MaxAttr-1:0]     ctx_i,
  input  wire  [MaxAttr-1:0]     rel_i,
  input  wire  [MaxAttr-1:0]     am_i,
  input  wire                    row_sel_i,
  input  wire  [MaxAttr-1:0]     row_data_i,
  input  wire  [MaxAttr-1:0]     col_sel_i,
  input  wire  [MaxAttr-1:0]     it_i,
  output logic                   du_o,
  output logic [MaxAttr-1:0]     rel_o,
  // token in from the left neighbour
  input  wire                    tv_i,
  input  wire                    tc_i,
  input  wire  [IdxW-1:0]        ti_i,
  input  wire  [KeyW-1:0]        tk_i,
  input  wire  [MaxAttr-1:0]     ta_i,
  // token out to the right neighbour
  output logic                   tv_o,
  output logic                   tc_o,
  output logic [IdxW-1:0]        ti_o,
  output logic [KeyW-1:0]        tk_o,
  output logic [MaxAttr-1:0]     ta_o
);
  import brc_pkg::*;

  logic [MaxAttr-1:0] ctx_q, rel_q;
  logic               valid_q;
  logic               col_q;
  logic [IdxW-1:0]    idx_q;
  logic [KeyW-1:0]    key_q;
  logic [MaxAttr-1:0] acc_q;
  logic               hit;
  logic [MaxAttr-1:0] acc_d;

  // row token: object holds all of s; column token: object is in the column set
  always_comb begin
    if (tc_i) begin
      hit = in_use_i && tk_i[CellIdx];
    end else begin
      hit = in_use_i && ((tk_i[MaxAttr-1:0] & ~ctx_q) == '0);
    end
    acc_d = hit ? (ta_i & ctx_q) : ta_i;
  end

  // dual bit for a column closure
  assign du_o  = in_use_i && ((it_i & ~ctx_q) == '0);
  assign rel_o = rel_q;

  // token valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tv_i;
    end
  end

  // token payload
  always_ff @(posedge clk_i) begin
    col_q <= tc_i;
    idx_q <= ti_i;
    key_q <= tk_i;
    acc_q <= acc_d;
  end

  // row storage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && load_sel_i) begin
      ctx_q <= ctx_i;
      rel_q <= rel_i;
    end else if (ctrl_i.mask && in_use_i) begin
      rel_q <= rel_q & am_i;
    end else if (row_sel_i) begin
      rel_q <= row_data_i;
    end else if (ctrl_i.col_we && in_use_i) begin
      rel_q <= (rel_q & ~col_sel_i) | ({MaxAttr{du_o}} & col_sel_i);
    end
  end

  assign tv_o = valid_q;
  assign tc_o = col_q;
  assign ti_o = idx_q;
  assign tk_o = key_q;
  assign ta_o = acc_q;

endmodule
`default_nettype wire

### rtl/core/bond_relation_closure.sv
// Top level: row loading, closure pass sequencer over the cell chain, result output.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------
//  input    | start_i, busy_o     | in_i   (in_beat_t)
//  result   | res_valid_o strobe  | res_o  (out_beat_t)
//  config   | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// Rows load one beat per cycle while idle. After the last row the block is busy:
// it masks the stored rows, then each pass feeds n row tokens and m column tokens
// through the MaxObj-cell chain. Then n result beats, one per cycle. Reset clears
// control state only; the receiver takes every result beat, there is no stall.
`default_nettype none
module bond_relation_closure #(
  parameter int MaxObj  = brc_pkg::DefMaxObjects,
  parameter int MaxAttr = brc_pkg::DefMaxAttributes
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  output logic                             busy_o,
  input  wire brc_pkg::in_beat_t           in_i,
  output logic                             res_valid_o,
  output brc_pkg::out_beat_t               res_o,
  input  wire                              cfg_we_i,
  input  wire  [brc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [brc_pkg::CfgDataW-1:0]     cfg_data_i
);
  import brc_pkg::*;

  localparam int KeyW = (MaxObj > MaxAttr) ? MaxObj : MaxAttr;
  localparam int IdxW = $clog2(KeyW);
  localparam int CntW = $clog2(KeyW + 1);
  localparam int NW   = $clog2(MaxObj + 1);
  localparam int MW   = $clog2(MaxAttr + 1);
  localparam int OW   = $clog2(MaxObj);
  localparam int AW   = $clog2(MaxAttr);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MASK   = 3'd1;
  localparam logic [2:0] S_ROWS   = 3'd2;
  localparam logic [2:0] S_RDRAIN = 3'd3;
  localparam logic [2:0] S_COLS   = 3'd4;
  localparam logic [2:0] S_CDRAIN = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  // configuration registers
  logic [CountW-1:0] num_obj_q, num_attr_q;
  logic [PassW-1:0]  max_pass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_obj_q  <= RstNumObjects;
      num_attr_q <= RstNumAttributes;
      max_pass_q <= RstMaxPasses;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNumObjects:    num_obj_q  <= cfg_data_i[CountW-1:0];
        CfgNumAttributes: num_attr_q <= cfg_data_i[CountW-1:0];
        CfgMaxPasses:     max_pass_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped counts, masks and pass limit
  logic [NW-1:0]      n_use;
  logic [MW-1:0]      m_use;
  logic [PassW-1:0]   limit;
  logic [MaxObj-1:0]  in_use;
  logic [MaxAttr-1:0] am;

  always_comb begin
    if (num_obj_q == '0) begin
      n_use = NW'(1);
    end else if ({1'b0, num_obj_q} > 7'(MaxObj)) begin
      n_use = NW'(MaxObj);
    end else begin
      n_use = NW'(num_obj_q);
    end
    if (num_attr_q == '0) begin
      m_use = MW'(1);
    end else if ({1'b0, num_attr_q} > 7'(MaxAttr)) begin
      m_use = MW'(MaxAttr);
    end else begin
      m_use = MW'(num_attr_q);
    end
    limit = (max_pass_q == '0) ? PassW'(1) : max_pass_q;
    for (int k = 0; k < MaxObj; k++) begin
      in_use[k] = n_use > NW'(k);
    end
    for (int b = 0; b < MaxAttr; b++) begin
      am[b] = m_use > MW'(b);
    end
  end

  // sequencer state
  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NW-1:0]   loaded_q, loaded_d;
  logic [PassW-1:0] pass_q, pass_d;
  logic            changed_q, changed_d;
  logic            strobe_q, strobe_d;
  out_beat_t       out_q, out_d;

  // chain wiring, index 0 is the injection point
  logic               tv [MaxObj+1];
  logic               tc [MaxObj+1];
  logic [IdxW-1:0]    ti [MaxObj+1];
  logic [KeyW-1:0]    tk [MaxObj+1];
  logic [MaxAttr-1:0] ta [MaxObj+1];
  logic [MaxAttr-1:0] rel_arr [MaxObj];
  logic [MaxObj-1:0]  du_vec;
  logic [MaxObj-1:0]  pipe_v;
  logic [MaxObj-1:0]  load_sel, row_sel;
  logic [MaxAttr-1:0] col_sel, ctx_in, rel_in, exit_res, it_bcast;
  logic [MaxObj-1:0]  sd;
  cell_ctrl_t         ctrl;
  logic               exit_row, exit_col, pipe_busy, last_cnt_n, last_cnt_m;

  // input row bits fitted to the attribute width
  always_comb begin
    for (int b = 0; b < MaxAttr; b++) begin
      ctx_in[b] = (b < RowW) ? in_i.context_row[b % RowW] : 1'b0;
      rel_in[b] = (b < RowW) ? in_i.relation_row[b % RowW] : 1'b0;
    end
  end

  assign last_cnt_n = cnt_q == (CntW'(n_use) - CntW'(1));
  assign last_cnt_m = cnt_q == (CntW'(m_use) - CntW'(1));

  // column set of the column being injected
  always_comb begin
    for (int i = 0; i < MaxObj; i++) begin
      sd[i] = in_use[i] && rel_arr[i][cnt_q[AW-1:0]];
    end
  end

  // token injection
  always_comb begin
    tv[0] = (state_q == S_ROWS) || (state_q == S_COLS);
    tc[0] = state_q == S_COLS;
    ti[0] = cnt_q[IdxW-1:0];
    tk[0] = (state_q == S_COLS) ? KeyW'(sd) : KeyW'(rel_arr[cnt_q[OW-1:0]]);
    ta[0] = '1;
  end

  // token exit from the far end of the chain
  assign exit_row  = tv[MaxObj] && !tc[MaxObj];
  assign exit_col  = tv[MaxObj] && tc[MaxObj];
  assign exit_res  = ta[MaxObj] & am;
  assign it_bcast  = exit_res;
  assign pipe_busy = |pipe_v;

  always_comb begin
    for (int k = 0; k < MaxObj; k++) begin
      load_sel[k] = loaded_q == NW'(k);
      row_sel[k]  = exit_row && (ti[MaxObj] == IdxW'(k));
    end
    for (int b = 0; b < MaxAttr; b++) begin
      col_sel[b] = ti[MaxObj] == IdxW'(b);
    end
  end

  assign ctrl.load   = (state_q == S_IDLE) && start_i;
  assign ctrl.mask   = state_q == S_MASK;
  assign ctrl.col_we = exit_col;

  // cell chain
  for (genvar k = 0; k < MaxObj; k++) begin : g_cell
    brc_cell #(
      .MaxObj  (MaxObj),
      .MaxAttr (MaxAttr),
      .CellIdx (k),
      .KeyW    (KeyW),
      .IdxW    (IdxW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .in_use_i   (in_use[k]),
      .load_sel_i (load_sel[k]),
      .ctx_i      (ctx_in),
      .rel_i      (rel_in),
      .am_i       (am),
      .row_sel_i  (row_sel[k]),
      .row_data_i (exit_res),
      .col_sel_i  (col_sel),
      .it_i       (it_bcast),
      .du_o       (du_vec[k]),
      .rel_o      (rel_arr[k]),
      .tv_i       (tv[k]),
      .tc_i       (tc[k]),
      .ti_i       (ti[k]),
      .tk_i       (tk[k]),
      .ta_i       (ta[k]),
      .tv_o       (tv[k+1]),
      .tc_o       (tc[k+1]),
      .ti_o       (ti[k+1]),
      .tk_o       (tk[k+1]),
      .ta_o       (ta[k+1])
    );
    assign pipe_v[k] = tv[k+1];
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    loaded_d  = loaded_q;
    pass_d    = pass_q;
    changed_d = changed_q;
    strobe_d  = 1'b0;
    out_d     = out_q;
    if (exit_row && (exit_res != tk[MaxObj][MaxAttr-1:0])) begin
      changed_d = 1'b1;
    end
    if (exit_col && (du_vec != tk[MaxObj][MaxObj-1:0])) begin
      changed_d = 1'b1;
    end
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (loaded_q != NW'(MaxObj)) begin
            loaded_d = loaded_q + NW'(1);
          end
          if (in_i.last_row) begin
            loaded_d = '0;
            state_d  = S_MASK;
          end
        end
      end
      S_MASK: begin
        pass_d    = PassW'(1);
        changed_d = 1'b0;
        cnt_d     = '0;
        state_d   = S_ROWS;
      end
      S_ROWS: begin
        cnt_d = cnt_q + CntW'(1);
        if (last_cnt_n) begin
          state_d = S_RDRAIN;
        end
      end
      S_RDRAIN: begin
        if (!pipe_busy) begin
          cnt_d   = '0;
          state_d = S_COLS;
        end
      end
      S_COLS: begin
        cnt_d = cnt_q + CntW'(1);
        if (last_cnt_m) begin
          state_d = S_CDRAIN;
        end
      end
      S_CDRAIN: begin
        if (!pipe_busy) begin
          cnt_d = '0;
          if (changed_q && (pass_q < limit)) begin
            pass_d    = pass_q + PassW'(1);
            changed_d = 1'b0;
            state_d   = S_ROWS;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        strobe_d = 1'b1;
        for (int b = 0; b < RowW; b++) begin
          out_d.result_row[b] = (b < MaxAttr) ? rel_arr[cnt_q[OW-1:0]][b % MaxAttr] : 1'b0;
        end
        for (int b = 0; b < RowIdxW; b++) begin
          out_d.row_index[b] = (b < CntW) ? cnt_q[b % CntW] : 1'b0;
        end
        out_d.last_result   = last_cnt_n;
        out_d.limit_reached = changed_q;
        cnt_d = cnt_q + CntW'(1);
        if (last_cnt_n) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      loaded_q  <= '0;
      pass_q    <= '0;
      changed_q <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      loaded_q  <= loaded_d;
      pass_q    <= pass_d;
      changed_q <= changed_d;
      strobe_q  <= strobe_d;
    end
  end

  // result beat register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign busy_o      = state_q != S_IDLE;
  assign res_valid_o = strobe_q;
  assign res_o       = out_q;

endmodule
`default_nettype wire
